[sv/pcbd_pkg.sv]
// Shared types and constants for the pulse-count backlight dimmer.
// No dependencies; every other file refers to this package by scoped names.
package pcbd_pkg;

  // Number of current steps in the LED driver and width of a level value
  localparam int LEVELS  = 32;
  localparam int LEVEL_W = 6;
  localparam int BR_W    = 8;

  // Control line actions
  localparam logic [1:0] ACT_OFF   = 2'd0;
  localparam logic [1:0] ACT_ON    = 2'd1;
  localparam logic [1:0] ACT_PULSE = 2'd2;

  // Item kinds
  localparam logic KIND_REQUEST = 1'b0;
  localparam logic KIND_LOAD    = 1'b1;

  // Configuration register indexes
  localparam logic [0:0] REG_BRIGHT_CAP   = 1'd0;
  localparam logic [0:0] REG_ACTIVE_LEVEL = 1'd1;

  // Search token that walks down the threshold chain
  typedef struct packed {
    logic               valid;
    logic [BR_W-1:0]    req;
    logic [LEVEL_W-1:0] level;   // level served by the cell it enters
    logic               found;
    logic [LEVEL_W-1:0] target;
  } probe_t;

  // Start command from the controller to the action emitter
  typedef struct packed {
    logic               go;
    logic [LEVEL_W-1:0] cur;
    logic [LEVEL_W-1:0] target;
    logic [BR_W-1:0]    req;
  } start_t;

endpackage

[sv/pcbd_cell.sv]
// One threshold cell of the search chain: holds one table entry and
// passes the search token to the next lower level. Uses pcbd_pkg.
module pcbd_cell (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     wr_en,
  input  logic [pcbd_pkg::BR_W-1:0] wr_value,
  input  pcbd_pkg::probe_t         probe_in,
  output pcbd_pkg::probe_t         probe_out
);

  logic [pcbd_pkg::BR_W-1:0] threshold;
  pcbd_pkg::probe_t          probe;

  // Hold the threshold for this level
  always_ff @(posedge clk) begin
    if (wr_en) begin
      threshold <= wr_value;
    end
  end

  // Advance the token one cell; claim it at the highest exceeded threshold
  always_ff @(posedge clk) begin
    probe.req   <= probe_in.req;
    probe.level <= probe_in.level - pcbd_pkg::LEVEL_W'(1);
    if (!probe_in.found && (probe_in.req > threshold)) begin
      probe.found  <= 1'b1;
      probe.target <= probe_in.level;
    end else begin
      probe.found  <= probe_in.found;
      probe.target <= probe_in.target;
    end
    if (rst) begin
      probe.valid <= 1'b0;
    end else begin
      probe.valid <= probe_in.valid;
    end
  end

  assign probe_out = probe;

endmodule

[sv/pcbd_emit.sv]
// Action emitter: steps the driver level from the start level to the target,
// one control line action per transfer, behind an output register. Uses pcbd_pkg.
module pcbd_emit (
  input  logic                         clk,
  input  logic                         rst,
  input  pcbd_pkg::start_t             start,
  input  logic                         active_level,
  output logic                         busy,
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic [1:0]                   action,
  output logic [pcbd_pkg::LEVEL_W-1:0] level_after,
  output logic                         pin_level,
  output logic [pcbd_pkg::BR_W-1:0]    stored_brightness,
  output logic                         last
);

  logic [pcbd_pkg::LEVEL_W-1:0] cur;
  logic [pcbd_pkg::LEVEL_W-1:0] target;
  logic [pcbd_pkg::BR_W-1:0]    kept_brightness;

  logic                         can_load;
  logic [1:0]                   act_next;
  logic [pcbd_pkg::LEVEL_W-1:0] lvl_next;

  assign can_load = busy && (!result_valid || !result_stall);

  // Pick the next action from the level the driver is at now
  always_comb begin
    if (target == '0) begin
      act_next = pcbd_pkg::ACT_OFF;
      lvl_next = '0;
    end else if (cur == '0) begin
      act_next = pcbd_pkg::ACT_ON;
      lvl_next = pcbd_pkg::LEVEL_W'(pcbd_pkg::LEVELS);
    end else begin
      act_next = pcbd_pkg::ACT_PULSE;
      lvl_next = (cur <= pcbd_pkg::LEVEL_W'(1)) ? pcbd_pkg::LEVEL_W'(pcbd_pkg::LEVELS)
                                                 : cur - pcbd_pkg::LEVEL_W'(1);
    end
  end

  // Sequence state
  always_ff @(posedge clk) begin
    if (rst) begin
      busy            <= 1'b0;
      kept_brightness <= '0;
    end else if (start.go) begin
      busy            <= 1'b1;
      cur             <= start.cur;
      target          <= start.target;
      kept_brightness <= start.req;
    end else if (can_load) begin
      cur  <= lvl_next;
      busy <= (lvl_next != target);
    end
  end

  // Output register; drop the valid once the transfer is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (can_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
    if (can_load) begin
      action            <= act_next;
      level_after       <= lvl_next;
      pin_level         <= (act_next == pcbd_pkg::ACT_OFF) ? ~active_level : active_level;
      stored_brightness <= kept_brightness;
      last              <= (lvl_next == target);
    end
  end

endmodule

[sv/pulse_count_backlight_dimmer.sv]
// Top level of the pulse-count backlight dimmer: item port, configuration,
// threshold cell chain and action emitter. Uses pcbd_pkg, pcbd_cell, pcbd_emit.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+-------------------------------------------
//  item     | item_valid / item_stall     | kind, requested_brightness, display_on,
//           |                             | entry_index, entry_value
//  result   | result_valid / result_stall | action, level_after, pin_level,
//           |                             | stored_brightness, last
//  config   | cfg_wen                     | cfg_index, cfg_data
//
// A load item writes one table entry. A request walks the token through every
// cell; a new level sets the emitter stepping, one action per transfer, and the
// input is released after the last action.
// item_stall is high from request acceptance until the cycle after its last
// action enters the output register; result_stall holds that register.
// Reset clears level and kept brightness and sets config to its defaults; the table is not cleared.
module pulse_count_backlight_dimmer (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  output logic                         item_stall,
  input  logic                         kind,
  input  logic [7:0]                   requested_brightness,
  input  logic                         display_on,
  input  logic [4:0]                   entry_index,
  input  logic [7:0]                   entry_value,
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic [1:0]                   action,
  output logic [5:0]                   level_after,
  output logic                         pin_level,
  output logic [7:0]                   stored_brightness,
  output logic                         last,
  input  logic                         cfg_wen,
  input  logic [0:0]                   cfg_index,
  input  logic [7:0]                   cfg_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]                   state;
  logic [7:0]                   bright_cap;
  logic                         ctrl_active_level;
  logic [pcbd_pkg::LEVEL_W-1:0] current_level;

  logic                         item_take;
  logic [7:0]                   req_clamped;
  logic [pcbd_pkg::LEVEL_W-1:0] found_level;
  logic                         emit_busy;

  pcbd_pkg::probe_t head;
  pcbd_pkg::probe_t chain [pcbd_pkg::LEVELS];
  pcbd_pkg::start_t start;

  assign item_stall = (state != ST_IDLE);
  assign item_take  = item_valid && !item_stall;

  // Force to zero when blanked, clamp to the configured maximum
  always_comb begin
    if (!display_on) begin
      req_clamped = '0;
    end else if (requested_brightness > bright_cap) begin
      req_clamped = bright_cap;
    end else begin
      req_clamped = requested_brightness;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bright_cap        <= 8'd255;
      ctrl_active_level <= 1'b1;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        pcbd_pkg::REG_BRIGHT_CAP:   bright_cap        <= cfg_data;
        pcbd_pkg::REG_ACTIVE_LEVEL: ctrl_active_level <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Token entering the top cell
  always_comb begin
    head.valid  = item_take && (kind == pcbd_pkg::KIND_REQUEST);
    head.req    = req_clamped;
    head.level  = pcbd_pkg::LEVEL_W'(pcbd_pkg::LEVELS);
    head.found  = 1'b0;
    head.target = '0;
  end

  // Threshold chain, top level first, tail at cell 0
  for (genvar i = 0; i < pcbd_pkg::LEVELS; i++) begin : g_cell
    logic wr_en;
    assign wr_en = item_take && (kind == pcbd_pkg::KIND_LOAD) &&
                   ({1'b0, entry_index} == pcbd_pkg::LEVEL_W'(i));
    pcbd_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .wr_en     (wr_en),
      .wr_value  (entry_value),
      .probe_in  ((i == pcbd_pkg::LEVELS - 1) ? head : chain[(i + 1) % pcbd_pkg::LEVELS]),
      .probe_out (chain[i])
    );
  end

  assign found_level = chain[0].found ? chain[0].target : '0;

  // Start the emitter when the search ends on a new level
  always_comb begin
    start.go     = (state == ST_SCAN) && chain[0].valid && (found_level != current_level);
    start.cur    = current_level;
    start.target = found_level;
    start.req    = chain[0].req;
  end

  // Request sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      current_level <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (head.valid) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (chain[0].valid) begin
            if (start.go) begin
              state         <= ST_EMIT;
              current_level <= found_level;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_EMIT: begin
          if (!emit_busy) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  pcbd_emit u_emit (
    .clk               (clk),
    .rst               (rst),
    .start             (start),
    .active_level      (ctrl_active_level),
    .busy              (emit_busy),
    .result_valid      (result_valid),
    .result_stall      (result_stall),
    .action            (action),
    .level_after       (level_after),
    .pin_level         (pin_level),
    .stored_brightness (stored_brightness),
    .last              (last)
  );

endmodule
